### rtl/core/bbwc_pkg.sv
`default_nettype none

package bbwc_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RESULT_W = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_BCD2BIN      = 2'd0,
    OP_BCD2BIN_PASS = 2'd1,
    OP_BIN2BCD4     = 2'd2,
    OP_BIN2BCD8     = 2'd3
  } op_e;

  // floor(v / 1000) = (v * M) >> S, exact over the stated input range
  localparam logic [31:0] RECIP1000_32   = 32'd2199023256;  // 32-bit v
  localparam int unsigned SHIFT1000_32   = 41;
  localparam logic [22:0] RECIP10_23     = 23'd6710887;     // 23-bit v
  localparam int unsigned SHIFT10_23     = 26;
  localparam logic [19:0] RECIP1000_19   = 20'd536871;      // 19-bit v
  localparam int unsigned SHIFT1000_19   = 29;

  localparam logic [9:0]  K1000    = 10'd1000;
  localparam logic [3:0]  K10      = 4'd10;
  localparam logic [3:0]  DIGIT_MAX = 4'd9;
  localparam logic [22:0] THOUS_MAX = 23'd9;
  localparam logic [18:0] BCD4_MAX  = 19'd9999;
  localparam logic [15:0] PASS_MASK = 16'h8000;

  typedef struct packed {
    op_e         op;
    logic [15:0] val16;
    logic [22:0] a;       // value div 1000
    logic [9:0]  b;       // value mod 1000
    logic [18:0] q;       // value div 10000
    logic [3:0]  c;       // (value div 1000) mod 10
    logic [8:0]  qt;      // q div 1000
    logic [11:0] bcd_b;   // three BCD digits of b
    logic [9:0]  rq;      // q mod 1000
    logic [15:0] bin_lo;  // BCD to binary result
    logic        bin_bad;
  } pipe_t;

  // Three-digit double dabble for values below 1000.
  function automatic logic [11:0] bcd3(input logic [9:0] n);
    logic [21:0] sh;
    int i;
    sh = {12'd0, n};
    for (i = 0; i < 10; i++) begin
      if (sh[13:10] > 4'd4) sh[13:10] = sh[13:10] + 4'd3;
      if (sh[17:14] > 4'd4) sh[17:14] = sh[17:14] + 4'd3;
      if (sh[21:18] > 4'd4) sh[21:18] = sh[21:18] + 4'd3;
      sh = sh << 1;
    end
    return sh[21:10];
  endfunction

endpackage

`default_nettype wire

### rtl/core/bbwc_in_if.sv
`default_nettype none

interface bbwc_in_if
  import bbwc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

### rtl/core/bbwc_out_if.sv
`default_nettype none

interface bbwc_out_if
  import bbwc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] result_low;
  logic [RESULT_W-1:0] result_high;
  logic                out_of_range;

  modport source (output valid, output result_low, output result_high,
                  output out_of_range, input ready);
  modport sink   (input valid, input result_low, input result_high,
                  input out_of_range, output ready);
endinterface

`default_nettype wire

### rtl/core/bcd_binary_word_converter_core.sv
`default_nettype none

// Packed BCD / binary word converter. One beat in gives one beat out: opcode 0
// turns four BCD digits into binary, opcode 1 does the same but passes a word
// with bit 15 set unchanged, opcode 2 gives four BCD digits of the value and
// opcode 3 gives eight (low word value mod 10000, high word value div 10000).
// out_of_range flags a nibble above nine or a value that the digits cannot hold.
// The block takes one beat per cycle while the output is not stalled. The
// pipeline depth is set by the chain of constant reciprocal multiplies
// (div 1000, div 10, div 1000 again), each in a register stage of its own.
// Stages that hold no beat let the next one in, so input is still taken
// while a finished result waits at the output.

module bcd_binary_word_converter_core
  import bbwc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bbwc_in_if.sink     in_i,
  bbwc_out_if.source  out_o
);

  localparam int unsigned NSTAGE = 6;

  logic [NSTAGE-1:0] valid_q, valid_d, en;

  op_e                op_q;
  logic [VALUE_W-1:0] value_q;
  pipe_t s1_d, s1_q, s2_d, s2_q, s3_d, s3_q, s4_d, s4_q;
  logic [RESULT_W-1:0] lo_d, lo_q, hi_d, hi_q;
  logic                bad_d, bad_q;

  logic [63:0] prod_a;
  logic [45:0] prod_q;
  logic [38:0] prod_qt;
  logic [9:0]  mul_b, mul_rq;
  logic [3:0]  mul_c;
  logic [3:0]  d3, d2, d1, d0;
  logic [14:0] wsum;

  // handshake
  always_comb begin
    en[NSTAGE-1] = !valid_q[NSTAGE-1] || out_o.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = en[0] ? in_i.valid : valid_q[0];
    for (int k = 1; k < NSTAGE; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stage 1: value div 1000, BCD to binary
  always_comb begin
    d3 = value_q[15:12];
    d2 = value_q[11:8];
    d1 = value_q[7:4];
    d0 = value_q[3:0];
    wsum = 15'(d3) * 15'd1000 + 15'(d2) * 15'd100 + 15'(d1) * 15'd10 + 15'(d0);
    prod_a = 64'(value_q) * 64'(RECIP1000_32);

    s1_d         = '0;
    s1_d.op      = op_q;
    s1_d.val16   = value_q[15:0];
    s1_d.a       = prod_a[SHIFT1000_32 +: 23];
    if (op_q == OP_BCD2BIN_PASS && (value_q[15:0] & PASS_MASK) != '0) begin
      s1_d.bin_lo  = value_q[15:0];
      s1_d.bin_bad = 1'b0;
    end else begin
      s1_d.bin_lo  = {1'b0, wsum};
      s1_d.bin_bad = (d3 > DIGIT_MAX) || (d2 > DIGIT_MAX) ||
                     (d1 > DIGIT_MAX) || (d0 > DIGIT_MAX);
    end
  end

  // stage 2: value mod 1000, value div 10000
  always_comb begin
    mul_b  = s1_q.a[9:0] * K1000;
    prod_q = 46'(s1_q.a) * 46'(RECIP10_23);
    s2_d   = s1_q;
    s2_d.b = s1_q.val16[9:0] - mul_b;
    s2_d.q = prod_q[SHIFT10_23 +: 19];
  end

  // stage 3: thousands digit of the low word, q div 1000, low digits
  always_comb begin
    mul_c      = s2_q.q[3:0] * K10;
    prod_qt    = 39'(s2_q.q) * 39'(RECIP1000_19);
    s3_d       = s2_q;
    s3_d.c     = s2_q.a[3:0] - mul_c;
    s3_d.qt    = prod_qt[SHIFT1000_19 +: 9];
    s3_d.bcd_b = bcd3(s2_q.b);
  end

  // stage 4: q mod 1000
  always_comb begin
    mul_rq  = {1'b0, s3_q.qt} * K1000;
    s4_d    = s3_q;
    s4_d.rq = s3_q.q[9:0] - mul_rq;
  end

  // stage 5: result
  always_comb begin
    lo_d  = s4_q.bin_lo;
    hi_d  = '0;
    bad_d = s4_q.bin_bad;
    unique case (s4_q.op)
      OP_BCD2BIN, OP_BCD2BIN_PASS: begin
        lo_d  = s4_q.bin_lo;
        bad_d = s4_q.bin_bad;
      end
      OP_BIN2BCD4: begin
        lo_d  = {s4_q.a[3:0], s4_q.bcd_b};
        bad_d = s4_q.a > THOUS_MAX;
      end
      OP_BIN2BCD8: begin
        lo_d  = {s4_q.c, s4_q.bcd_b};
        hi_d  = {s4_q.qt[3:0], bcd3(s4_q.rq)};
        bad_d = s4_q.q > BCD4_MAX;
      end
      default: begin
        lo_d  = s4_q.bin_lo;
        bad_d = s4_q.bin_bad;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      op_q    <= op_e'(in_i.opcode);
      value_q <= in_i.value;
    end
    if (en[1]) s1_q <= s1_d;
    if (en[2]) s2_q <= s2_d;
    if (en[3]) s3_q <= s3_d;
    if (en[4]) s4_q <= s4_d;
    if (en[5]) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      bad_q <= bad_d;
    end
  end

  assign out_o.valid        = valid_q[NSTAGE-1];
  assign out_o.result_low   = lo_q;
  assign out_o.result_high  = hi_q;
  assign out_o.out_of_range = bad_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> valid_q[0])
    else $error("accepted beat not captured");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> &valid_q)
    else $error("input stalled with an empty stage");

  a_mod1000: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> s2_q.b < K1000)
    else $error("value mod 1000 out of range");

  a_mod10: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] |-> s3_q.c < K10)
    else $error("thousands digit out of range");

  a_q_mod1000: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] |-> s4_q.rq < K1000)
    else $error("high word remainder out of range");

endmodule

`default_nettype wire

### dv/bbwc_word_checker.sv
`timescale 1ns / 1ps

module bbwc_word_checker
  import bbwc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  bbwc_in_if                in_mon,
  bbwc_out_if               out_mon,
  output int unsigned       fail_cnt_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [RESULT_W-1:0] lo;
    logic [RESULT_W-1:0] hi;
    logic                oor;
  } word_res_t;

  word_res_t expected_words[$];

  // Weighted sum of four nibbles, each at face value.
  function automatic logic [15:0] bcd_word_value(input logic [15:0] w, output logic bad);
    int unsigned sum;
    sum = int'(w[15:12]) * 1000 + int'(w[11:8]) * 100 + int'(w[7:4]) * 10 + int'(w[3:0]);
    bad = (w[15:12] > 4'd9) || (w[11:8] > 4'd9) || (w[7:4] > 4'd9) || (w[3:0] > 4'd9);
    return sum[15:0];
  endfunction

  // Four BCD digits; thousands digit keeps only its low 4 bits.
  function automatic logic [15:0] bin_word_digits(input int unsigned v, output logic bad);
    int unsigned th, rem, hu, te, un;
    th  = v / 1000;
    rem = v % 1000;
    hu  = rem / 100;
    te  = (rem % 100) / 10;
    un  = rem % 10;
    bad = v > 9999;
    return {th[3:0], hu[3:0], te[3:0], un[3:0]};
  endfunction

  function automatic word_res_t convert_word(input op_e op, input logic [VALUE_W-1:0] v);
    word_res_t r;
    logic      unused_bad;
    r = '0;
    case (op)
      OP_BCD2BIN: begin
        r.lo = bcd_word_value(v[15:0], r.oor);
      end
      OP_BCD2BIN_PASS: begin
        if (v[15]) begin
          r.lo = v[15:0];
        end else begin
          r.lo = bcd_word_value(v[15:0], r.oor);
        end
      end
      OP_BIN2BCD4: begin
        r.lo = bin_word_digits(v, r.oor);
      end
      default: begin
        r.lo = bin_word_digits(v % 10000, unused_bad);
        r.hi = bin_word_digits(v / 10000, r.oor);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_res_t   want;
    int unsigned errs;
    if (!rst_ni) begin
      expected_words.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      errs = 0;
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result beat: result_low=%h result_high=%h out_of_range=%b",
                 out_mon.result_low, out_mon.result_high, out_mon.out_of_range);
          errs++;
        end else begin
          want = expected_words.pop_front();
          if (out_mon.result_low !== want.lo) begin
            $error("result_low: expected %h, actual %h", want.lo, out_mon.result_low);
            errs++;
          end
          if (out_mon.result_high !== want.hi) begin
            $error("result_high: expected %h, actual %h", want.hi, out_mon.result_high);
            errs++;
          end
          if (out_mon.out_of_range !== want.oor) begin
            $error("out_of_range: expected %b, actual %b", want.oor, out_mon.out_of_range);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_words.push_back(convert_word(op_e'(in_mon.opcode), in_mon.value));
      end
      fail_cnt_o <= fail_cnt_o + errs;
      pending_o  <= expected_words.size();
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import bbwc_pkg::*;
;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;
  bit          src_no_idle;
  bit          sink_no_stall;

  bbwc_in_if  in_if();
  bbwc_out_if out_if();

  bcd_binary_word_converter_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bbwc_word_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap(input bit no_idle);
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] random_bcd_word();
    logic [VALUE_W-1:0] w;
    int i;
    w = $urandom();
    for (i = 0; i < 4; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        w[i*4 +: 4] = 4'($urandom_range(10, 15));
      end else begin
        w[i*4 +: 4] = 4'($urandom_range(0, 9));
      end
    end
    return w;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned r;
    int unsigned edges[6];
    edges = '{0, 9999, 10000, 99999999, 100000000, 32'hFFFF_FFFF};
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: return $urandom();
      3, 4:    return random_bcd_word();
      5, 6:    return $urandom_range(0, 9999);
      7:       return $urandom_range(0, 99999999);
      8:       return edges[$urandom_range(0, 5)] + $urandom_range(0, 4) - 2;
      default: return $urandom_range(0, 20000);
    endcase
  endfunction

  task automatic send_beat(input op_e op, input logic [VALUE_W-1:0] v);
    int unsigned gap;
    gap = pick_gap(src_no_idle);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.value  <= v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sink side: random stalls, with stall-free stretches.
  initial begin
    int unsigned stall_left;
    int unsigned cyc;
    stall_left = 0;
    cyc = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 200 == 0) sink_no_stall = ($urandom_range(0, 3) == 0);
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap(sink_no_stall);
      end
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.opcode = '0;
    in_if.value  = '0;
    src_no_idle   = 1'b0;
    sink_no_stall = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_beat(OP_BCD2BIN, 32'h0000_0000);
    send_beat(OP_BCD2BIN, 32'h0000_9999);
    send_beat(OP_BCD2BIN, 32'h0000_FFFF);
    send_beat(OP_BCD2BIN, 32'hFFFF_1234);
    send_beat(OP_BCD2BIN, 32'h0000_000A);
    send_beat(OP_BCD2BIN, 32'h0000_A000);
    send_beat(OP_BCD2BIN_PASS, 32'h0000_8000);
    send_beat(OP_BCD2BIN_PASS, 32'hFFFF_FFFF);
    send_beat(OP_BCD2BIN_PASS, 32'h0000_7999);
    send_beat(OP_BCD2BIN_PASS, 32'h0000_7FFF);
    send_beat(OP_BCD2BIN_PASS, 32'hABCD_0099);
    send_beat(OP_BIN2BCD4, 32'd0);
    send_beat(OP_BIN2BCD4, 32'd9999);
    send_beat(OP_BIN2BCD4, 32'd10000);
    send_beat(OP_BIN2BCD4, 32'd16000);
    send_beat(OP_BIN2BCD4, 32'hFFFF_FFFF);
    send_beat(OP_BIN2BCD8, 32'd0);
    send_beat(OP_BIN2BCD8, 32'd9999);
    send_beat(OP_BIN2BCD8, 32'd10000);
    send_beat(OP_BIN2BCD8, 32'd12345678);
    send_beat(OP_BIN2BCD8, 32'd99999999);
    send_beat(OP_BIN2BCD8, 32'd100000000);
    send_beat(OP_BIN2BCD8, 32'hFFFF_FFFF);

    for (int i = 0; i < 1030; i++) begin
      if (i % 100 == 0) src_no_idle = ($urandom_range(0, 3) == 0);
      send_beat(op_e'($urandom_range(0, 3)), random_value());
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/bbwc_pkg.sv
rtl/core/bbwc_in_if.sv
rtl/core/bbwc_out_if.sv
rtl/core/bcd_binary_word_converter_core.sv
dv/bbwc_word_checker.sv
dv/tb_top.sv
